>>> src/ltdf_pkg.sv
// Shared constants and transaction types for the lattice to direct-form converter.
// Depends on nothing; the top level imports it.
package ltdf_pkg;

	// Sizing of the coefficient store.
	localparam int MAX_ORDER   = 32;
	localparam int STORE_WIDTH = 32;
	localparam int STORE_FRAC  = 24;

	// Fixed field formats.
	localparam int REFL_W    = 16;
	localparam int REFL_FRAC = 15;
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 16;
	localparam int OUT_W     = 32;
	localparam int OUT_FRAC  = 20;
	localparam int IDX_W     = 6;

	// Derived widths.
	localparam int CNT_W  = $clog2(MAX_ORDER + 1);
	localparam int ADDR_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	// Result status codes.
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_OVF = 2'd2;

	typedef struct packed {
		logic signed [REFL_W-1:0] refl_coeff;
		logic signed [GAIN_W-1:0] gain;
		logic                     last;
	} refl_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] coeff;
		logic [IDX_W-1:0]        index;
		logic                    last_out;
		logic [1:0]              status;
	} coef_item_t;

endpackage

>>> src/ltdf_ram.sv
// Generic synchronous RAM: one write port and two read ports with registered read data.
// Self-contained; used for both banks of the coefficient store.
module ltdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

>>> src/lattice_to_direct_form_unit.sv
// Top level of the lattice to direct-form converter (step-up recursion).
// Depends on ltdf_pkg for constants and transaction types, and on ltdf_ram for the store.
//
// Reflection coefficients k1..kN enter one transaction at a time on the refl channel and
// are folded into a direct-form coefficient vector held in two ping-pong RAM banks: an
// update for order i reads the previous vector from one bank (two read ports, entries m
// and i-m), runs one multiply, round and saturating add per cycle, and writes the new
// vector into the other bank, which then becomes current. A reflection transaction of
// order i occupies the block while the single multiply-accumulate lane handles one
// entry per cycle, and then while the RAM read and the two-stage pipeline drain. A
// transaction flagged last then emits N + 1 result transactions on the coef channel:
// the gain term first (index 0), then -a[m] * gain for m = 1..N, each passing through
// a RAM read, a multiply and a round and clamp, and waiting while the consumer has not
// taken the previous result. The result register decouples the two sides, so the
// next set may start while the final result still waits. Values are saturated to the
// store and output widths; status reports 1 once any saturation has happened in the
// current set, and 2 when more than MAX_ORDER coefficients arrived, in which case extra
// coefficients are dropped and the run is emitted with N = MAX_ORDER. The counters and
// flags clear after the last result of a run. The store needs no clearing after reset,
// since the recursion only reads entries written earlier in the same set.
module lattice_to_direct_form_unit
	import ltdf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       refl_valid,
	output logic       refl_ready,
	input  refl_item_t refl_data,
	output logic       coef_valid,
	input  logic       coef_ready,
	output coef_item_t coef_data
);

	// Update datapath widths.
	localparam int PROD_W   = REFL_W + STORE_WIDTH;
	localparam int TERM_W   = PROD_W - REFL_FRAC;
	localparam int NEW_SH   = STORE_FRAC - REFL_FRAC;
	localparam int NEW_W    = REFL_W + 1 + NEW_SH;
	localparam int SUM_W0   = STORE_WIDTH + 2;
	localparam int NW       = ((NEW_W > SUM_W0) ? NEW_W : SUM_W0) + 1;

	// Output datapath widths.
	localparam int NG_W     = GAIN_W + 1;
	localparam int OP_W     = STORE_WIDTH + NG_W;
	localparam int OSH      = STORE_FRAC + GAIN_FRAC - OUT_FRAC;
	localparam int OR_W     = OP_W - OSH;
	localparam int CW       = ((OR_W > OUT_W) ? OR_W : OUT_W) + 1;
	localparam int GAIN_SH  = OUT_FRAC - GAIN_FRAC;

	localparam logic [PROD_W-1:0] UPD_RND = PROD_W'(64'd1 << (REFL_FRAC - 1));
	localparam logic [OP_W-1:0]   OUT_RND = OP_W'(64'd1 << (OSH - 1));

	localparam logic signed [NW-1:0] S_MAX = NW'((64'sd1 <<< (STORE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [NW-1:0] S_MIN = -S_MAX - NW'(1);
	localparam logic signed [CW-1:0] O_MAX = CW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [CW-1:0] O_MIN = -O_MAX - CW'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_DRAIN,
		S_GAIN,
		S_ORD,
		S_OMUL,
		S_OWR
	} state_t;

	state_t state_q;

	logic signed [REFL_W-1:0] k_q;
	logic signed [GAIN_W-1:0] g_q;
	logic                     last_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         m_q;
	logic                     bank_q;
	logic                     sat_q;
	logic                     ovf_q;
	logic                     coef_valid_q;
	coef_item_t               coef_data_q;

	// Update pipeline.
	logic                           v_s1, v_s2;
	logic                           new_s1, new_s2;
	logic [CNT_W-1:0]               m_s1, m_s2;
	logic signed [PROD_W-1:0]       prod_s2;
	logic signed [STORE_WIDTH-1:0]  old_s2;

	// Output multiplier register.
	logic signed [OP_W-1:0] prod_o_q;

	logic                 refl_fire;
	logic                 out_free;
	logic [CNT_W-1:0]     upd_top;
	logic [CNT_W-1:0]     mirror;
	logic [ADDR_W-1:0]    raddr_a, raddr_b, waddr;
	logic [STORE_WIDTH-1:0] rdata_a0, rdata_b0, rdata_a1, rdata_b1;
	logic signed [STORE_WIDTH-1:0] rd_a, rd_b;
	logic we0, we1;

	assign refl_ready = (state_q == S_IDLE);
	assign refl_fire  = refl_valid && refl_ready;
	assign out_free   = !coef_valid_q || coef_ready;
	assign coef_valid = coef_valid_q;
	assign coef_data  = coef_data_q;

	// Order of the vector being built, and the mirrored entry i - m.
	assign upd_top = cnt_q + CNT_W'(1);
	assign mirror  = upd_top - m_q - CNT_W'(1);

	assign raddr_a = ADDR_W'(m_q - CNT_W'(1));
	assign raddr_b = (m_q < upd_top) ? ADDR_W'(mirror) : '0;
	assign waddr   = ADDR_W'(m_s2 - CNT_W'(1));

	assign rd_a = bank_q ? rdata_a1 : rdata_a0;
	assign rd_b = bank_q ? rdata_b1 : rdata_b0;

	// The new vector always goes to the bank that is not current.
	assign we0 = v_s2 && bank_q;
	assign we1 = v_s2 && !bank_q;

	// Write stage: either the fresh entry -k or old[m] plus the rounded product term.
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [TERM_W-1:0] term;
	logic signed [NW-1:0]     new_val;
	logic signed [NW-1:0]     cand;
	logic                     upd_sat;
	logic [STORE_WIDTH-1:0]   wdata;

	assign prod_rnd = prod_s2 + UPD_RND;
	assign term     = prod_rnd[PROD_W-1:REFL_FRAC];
	assign new_val  = (-NW'(k_q)) <<< NEW_SH;
	assign cand     = new_s2 ? new_val : (NW'(old_s2) + NW'(term));

	always_comb begin
		upd_sat = 1'b0;
		wdata   = cand[STORE_WIDTH-1:0];
		if (cand > S_MAX) begin
			upd_sat = 1'b1;
			wdata   = S_MAX[STORE_WIDTH-1:0];
		end else if (cand < S_MIN) begin
			upd_sat = 1'b1;
			wdata   = S_MIN[STORE_WIDTH-1:0];
		end
	end

	// Output scaling: round a * (-g) to the output format and clamp.
	logic signed [NG_W-1:0] neg_g;
	logic signed [OP_W-1:0] prod_o_rnd;
	logic signed [OR_W-1:0] o_shift;
	logic signed [CW-1:0]   o_ext;
	logic signed [OUT_W-1:0] o_val;
	logic                   o_sat;
	logic [1:0]             o_status;
	logic [1:0]             g_status;
	logic signed [OUT_W-1:0] gain_val;

	assign neg_g      = -NG_W'(g_q);
	assign prod_o_rnd = prod_o_q + OUT_RND;
	assign o_shift    = prod_o_rnd[OP_W-1:OSH];
	assign o_ext      = CW'(o_shift);
	assign gain_val   = OUT_W'(g_q) <<< GAIN_SH;

	always_comb begin
		o_sat = 1'b0;
		o_val = o_ext[OUT_W-1:0];
		if (o_ext > O_MAX) begin
			o_sat = 1'b1;
			o_val = O_MAX[OUT_W-1:0];
		end else if (o_ext < O_MIN) begin
			o_sat = 1'b1;
			o_val = O_MIN[OUT_W-1:0];
		end
	end

	always_comb begin
		priority if (ovf_q) begin
			o_status = ST_OVF;
			g_status = ST_OVF;
		end else begin
			o_status = (sat_q || o_sat) ? ST_SAT : ST_OK;
			g_status = sat_q ? ST_SAT : ST_OK;
		end
	end

	// Coefficient store banks.
	ltdf_ram #(
		.WIDTH(STORE_WIDTH),
		.DEPTH(MAX_ORDER)
	) u_bank0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a0),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b0)
	);

	ltdf_ram #(
		.WIDTH(STORE_WIDTH),
		.DEPTH(MAX_ORDER)
	) u_bank1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.rdata_a(rdata_a1),
		.raddr_b(raddr_b),
		.rdata_b(rdata_b1)
	);

	// Update pipeline: issue reads, then multiply, then round, add and write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_UPD);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		new_s1   <= (m_q == upd_top);
		m_s1     <= m_q;
		new_s2   <= new_s1;
		m_s2     <= m_s1;
		prod_s2  <= k_q * rd_b;
		old_s2   <= rd_a;
		if (state_q == S_OMUL) begin
			prod_o_q <= rd_a * neg_g;
		end
	end

	// Sequencer, counters, flags and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			k_q          <= '0;
			g_q          <= '0;
			last_q       <= 1'b0;
			cnt_q        <= '0;
			m_q          <= '0;
			bank_q       <= 1'b0;
			sat_q        <= 1'b0;
			ovf_q        <= 1'b0;
			coef_valid_q <= 1'b0;
			coef_data_q  <= '0;
		end else begin
			if (coef_valid_q && coef_ready) begin
				coef_valid_q <= 1'b0;
			end
			if (v_s2 && upd_sat) begin
				sat_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (refl_fire) begin
						k_q    <= refl_data.refl_coeff;
						g_q    <= refl_data.gain;
						last_q <= refl_data.last;
						if (cnt_q == CNT_W'(MAX_ORDER)) begin
							// Extra coefficient: store untouched.
							ovf_q   <= 1'b1;
							state_q <= refl_data.last ? S_GAIN : S_IDLE;
						end else begin
							m_q     <= CNT_W'(1);
							state_q <= S_UPD;
						end
					end
				end
				S_UPD: begin
					if (m_q == upd_top) begin
						state_q <= S_DRAIN;
					end else begin
						m_q <= m_q + CNT_W'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						bank_q  <= !bank_q;
						cnt_q   <= upd_top;
						state_q <= last_q ? S_GAIN : S_IDLE;
					end
				end
				S_GAIN: begin
					if (out_free) begin
						coef_valid_q         <= 1'b1;
						coef_data_q.coeff    <= gain_val;
						coef_data_q.index    <= '0;
						coef_data_q.last_out <= (cnt_q == '0);
						coef_data_q.status   <= g_status;
						if (cnt_q == '0) begin
							sat_q   <= 1'b0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							m_q     <= CNT_W'(1);
							state_q <= S_ORD;
						end
					end
				end
				S_ORD: begin
					state_q <= S_OMUL;
				end
				S_OMUL: begin
					state_q <= S_OWR;
				end
				S_OWR: begin
					if (out_free) begin
						coef_valid_q         <= 1'b1;
						coef_data_q.coeff    <= o_val;
						coef_data_q.index    <= IDX_W'(m_q);
						coef_data_q.last_out <= (m_q == cnt_q);
						coef_data_q.status   <= o_status;
						if (m_q == cnt_q) begin
							cnt_q   <= '0;
							sat_q   <= 1'b0;
							ovf_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							if (o_sat) begin
								sat_q <= 1'b1;
							end
							m_q     <= m_q + CNT_W'(1);
							state_q <= S_ORD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The update pipeline is empty whenever a new transaction can be taken.
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!v_s1 && !v_s2))
		else $error("update pipeline busy while idle");

	// Store writes only happen while an update is in flight.
	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == S_UPD || state_q == S_DRAIN))
		else $error("store write outside of an update");

	// Overflow can only be flagged once the store is full.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (cnt_q == CNT_W'(MAX_ORDER)))
		else $error("overflow flag without a full store");

	// Output reads stay inside the written part of the vector.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OWR) |-> (m_q != '0 && m_q <= cnt_q))
		else $error("output index outside the current order");

endmodule
